### rtl/ultrasonic_echo_ranger_macros.svh
// Assertion macros shared by the ultrasonic echo ranger RTL.
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define UER_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ultrasonic_echo_ranger: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ultrasonic_echo_ranger: next-cycle check failed");

`endif

### rtl/uer_pkg.sv
// Shared types and constants of the ultrasonic echo ranger.
package uer_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 16;
    localparam int unsigned RETRY_GAP_TICKS = 10;
    localparam int unsigned GAP_W           = 4;
    localparam int unsigned DIST_MAX        = 32767;
    localparam int unsigned SPEED_SHIFT     = 17;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    // register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_RETRY_ENABLE = 3'd0,
        REG_MAX_ATTEMPTS = 3'd1,
        REG_BAD_VALUE    = 3'd2,
        REG_MIN_DISTANCE = 3'd3,
        REG_MAX_DISTANCE = 3'd4,
        REG_SPEED_SCALE  = 3'd5
    } t_reg_idx;

    localparam logic               RST_RETRY_ENABLE = 1'b1;
    localparam logic        [7:0]  RST_MAX_ATTEMPTS = 8'd3;
    localparam logic signed [15:0] RST_BAD_VALUE    = -16'sd1;
    localparam logic signed [15:0] RST_MIN_DISTANCE = 16'sd0;
    localparam logic signed [15:0] RST_MAX_DISTANCE = 16'sd400;
    localparam logic        [15:0] RST_SPEED_SCALE  = 16'd2248;

    typedef struct packed {
        logic               retry_enable;
        logic        [7:0]  max_attempts;
        logic signed [15:0] bad_value;
        logic signed [15:0] min_distance;
        logic signed [15:0] max_distance;
        logic        [15:0] speed_scale;
    } t_cfg;

    typedef struct packed {
        logic [14:0] distance;
        logic        in_window;
    } t_dist;

    typedef struct packed {
        logic               trigger_level;
        logic               done_res;
        logic signed [15:0] range_value;
        logic               bad_reading;
        logic               busy_res;
    } t_res;

endpackage

### rtl/uer_regs.sv
// APB configuration registers of the ultrasonic echo ranger.
module uer_regs
    import uer_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_enable <= RST_RETRY_ENABLE;
            r_cfg.max_attempts <= RST_MAX_ATTEMPTS;
            r_cfg.bad_value    <= RST_BAD_VALUE;
            r_cfg.min_distance <= RST_MIN_DISTANCE;
            r_cfg.max_distance <= RST_MAX_DISTANCE;
            r_cfg.speed_scale  <= RST_SPEED_SCALE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RETRY_ENABLE: r_cfg.retry_enable <= pwdata[0];
                REG_MAX_ATTEMPTS: r_cfg.max_attempts <= pwdata[7:0];
                REG_BAD_VALUE:    r_cfg.bad_value    <= $signed(pwdata[15:0]);
                REG_MIN_DISTANCE: r_cfg.min_distance <= $signed(pwdata[15:0]);
                REG_MAX_DISTANCE: r_cfg.max_distance <= $signed(pwdata[15:0]);
                REG_SPEED_SCALE:  r_cfg.speed_scale  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_RETRY_ENABLE: prdata = APB_DATA_W'(r_cfg.retry_enable);
            REG_MAX_ATTEMPTS: prdata = APB_DATA_W'(r_cfg.max_attempts);
            REG_BAD_VALUE:    prdata = APB_DATA_W'($unsigned(r_cfg.bad_value));
            REG_MIN_DISTANCE: prdata = APB_DATA_W'($unsigned(r_cfg.min_distance));
            REG_MAX_DISTANCE: prdata = APB_DATA_W'($unsigned(r_cfg.max_distance));
            REG_SPEED_SCALE:  prdata = APB_DATA_W'(r_cfg.speed_scale);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/uer_dist.sv
// Pulse count to distance scaling, saturation and window check.
module uer_dist
    import uer_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic [COUNT_WIDTH-1:0] i_pulse_count,
    input  t_cfg                   i_cfg,
    output t_dist                  o_dist
);

    localparam int unsigned PROD_W = COUNT_WIDTH + 16;

    logic [PROD_W-1:0]  w_prod;
    logic [31:0]        w_scaled;
    logic [14:0]        w_dist;
    logic signed [15:0] w_sdist;

    // Q0.16 speed times ticks, halved for the round trip: >> 17
    assign w_prod   = PROD_W'(i_pulse_count) * PROD_W'(i_cfg.speed_scale);
    assign w_scaled = 32'(w_prod >> SPEED_SHIFT);
    assign w_dist   = (w_scaled > 32'(DIST_MAX)) ? 15'(DIST_MAX) : w_scaled[14:0];
    assign w_sdist  = $signed({1'b0, w_dist});

    assign o_dist.distance  = w_dist;
    assign o_dist.in_window = (w_sdist >= i_cfg.min_distance) &&
                              (w_sdist <= i_cfg.max_distance);

endmodule

### rtl/uer_ctrl.sv
// Ranging sequencer: attempt, echo count and retry gap state.
module uer_ctrl
    import uer_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic                   i_start_req,
    input  logic                   i_echo_level,
    input  t_cfg                   i_cfg,
    input  t_dist                  i_dist,
    output logic [COUNT_WIDTH-1:0] o_pulse_count,
    output t_res                   o_res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_COUNT,
        PH_GAP
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_pulse, n_pulse;
    logic [7:0]             r_att, n_att;
    logic [GAP_W-1:0]       r_gap, n_gap;
    logic                   w_done, w_bad;
    logic signed [15:0]     w_value;
    logic                   w_left;

    assign w_left = r_att < i_cfg.max_attempts;

    always_comb begin
        n_phase = r_phase;
        n_pulse = r_pulse;
        n_att   = r_att;
        n_gap   = r_gap;
        w_done  = 1'b0;
        w_bad   = 1'b0;
        w_value = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_att = '0;
                    if (i_cfg.max_attempts == 8'd0) begin
                        w_done  = 1'b1;
                        w_bad   = 1'b1;
                        w_value = i_cfg.bad_value;
                    end else begin
                        n_att   = 8'd1;
                        n_pulse = '0;
                        n_gap   = '0;
                        n_phase = PH_WAIT;
                    end
                end
            end
            PH_WAIT: begin
                if (i_echo_level) begin
                    n_pulse = COUNT_WIDTH'(1);
                    n_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (i_echo_level) begin
                    if (r_pulse != {COUNT_WIDTH{1'b1}}) begin
                        n_pulse = r_pulse + COUNT_WIDTH'(1);
                    end
                end else if (i_dist.in_window) begin
                    w_done  = 1'b1;
                    w_value = $signed({1'b0, i_dist.distance});
                    n_phase = PH_IDLE;
                end else if (i_cfg.retry_enable) begin
                    n_gap   = GAP_W'(1);
                    n_phase = PH_GAP;
                    // one-tick gap: next attempt decided right away
                    if (RETRY_GAP_TICKS <= 1) begin
                        if (w_left) begin
                            n_att   = r_att + 8'd1;
                            n_pulse = '0;
                            n_gap   = '0;
                            n_phase = PH_WAIT;
                        end else begin
                            w_done  = 1'b1;
                            w_bad   = 1'b1;
                            w_value = i_cfg.bad_value;
                            n_phase = PH_IDLE;
                        end
                    end
                end else begin
                    w_done  = 1'b1;
                    w_bad   = 1'b1;
                    w_value = i_cfg.bad_value;
                    n_phase = PH_IDLE;
                end
            end
            PH_GAP: begin
                n_gap = r_gap + GAP_W'(1);
                if (n_gap >= GAP_W'(RETRY_GAP_TICKS)) begin
                    if (w_left) begin
                        n_att   = r_att + 8'd1;
                        n_pulse = '0;
                        n_gap   = '0;
                        n_phase = PH_WAIT;
                    end else begin
                        w_done  = 1'b1;
                        w_bad   = 1'b1;
                        w_value = i_cfg.bad_value;
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pulse <= '0;
            r_att   <= '0;
            r_gap   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pulse <= n_pulse;
            r_att   <= n_att;
            r_gap   <= n_gap;
        end
    end

    assign o_pulse_count       = r_pulse;
    assign o_res.trigger_level = !((n_phase == PH_WAIT) || (n_phase == PH_COUNT));
    assign o_res.done_res      = w_done;
    assign o_res.range_value   = w_value;
    assign o_res.bad_reading   = w_bad;
    assign o_res.busy_res      = n_phase != PH_IDLE;

endmodule

### rtl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: tick pipeline, sequencer and registers.
//
//   channel   direction  handshake            payload
//   -------   ---------  -------------------  ------------------------------------------
//   sample    in         i_valid / o_ready    i_start_req, i_echo_level
//   result    out        o_valid / i_ready    o_trigger_level, o_done_res, o_range_value,
//                                             o_bad_reading, o_busy_res
//   config    in         APB psel / penable   paddr, pwdata, prdata, pready (always 1)
//
// One transfer in gives one transfer out; one sample per cycle while i_ready holds.
// Each sample passes the input register, then the sequencer step into the
// result register. The step path holds the count-times-speed multiply and the
// window compare. Reset is synchronous, active low; it restores the register
// defaults and leaves the sequencer idle. A stalled result holds the result
// register; the input register still fills, then o_ready drops.
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_start_req,
    input  logic                  i_echo_level,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_trigger_level,
    output logic                  o_done_res,
    output logic signed [15:0]    o_range_value,
    output logic                  o_bad_reading,
    output logic                  o_busy_res,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

`include "ultrasonic_echo_ranger_macros.svh"

    // input register
    logic r_in_vld;
    logic r_start;
    logic r_echo;

    // result register
    logic r_out_vld;
    t_res r_res;

    t_cfg                   w_cfg;
    t_dist                  w_dist;
    t_res                   w_res;
    logic [COUNT_WIDTH-1:0] w_pulse;
    logic                   w_fire;

    // the sequencer steps when a sample sits in the input register and the
    // result register is empty or being emptied this cycle
    assign w_fire  = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || w_fire;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (w_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_start <= i_start_req;
            r_echo  <= i_echo_level;
        end
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    uer_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    uer_dist #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dist (
        .i_pulse_count (w_pulse),
        .i_cfg         (w_cfg),
        .o_dist        (w_dist)
    );

    uer_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_fire),
        .i_start_req   (r_start),
        .i_echo_level  (r_echo),
        .i_cfg         (w_cfg),
        .i_dist        (w_dist),
        .o_pulse_count (w_pulse),
        .o_res         (w_res)
    );

    assign o_valid         = r_out_vld;
    assign o_trigger_level = r_res.trigger_level;
    assign o_done_res      = r_res.done_res;
    assign o_range_value   = r_res.range_value;
    assign o_bad_reading   = r_res.bad_reading;
    assign o_busy_res      = r_res.busy_res;

    // a good reading always lies inside the configured window
    `UER_ASSERT_NOW(a_good_in_window, i_clk, i_rst_n, o_valid && o_done_res && !o_bad_reading, (o_range_value >= w_cfg.min_distance) && (o_range_value <= w_cfg.max_distance))
    // a failed ranging reports the configured bad value
    `UER_ASSERT_NOW(a_bad_value, i_clk, i_rst_n, o_valid && o_done_res && o_bad_reading, o_range_value == w_cfg.bad_value)
    // done ends the ranging: trigger back high, no longer busy
    `UER_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_valid && o_done_res, !o_busy_res && o_trigger_level)
    // a taken result with nothing behind it leaves the output empty
    `UER_ASSERT_NEXT(a_drain, i_clk, i_rst_n, o_valid && i_ready && !w_fire, !o_valid)

endmodule

### bench/testbench.sv
// Self-checking testbench for the ultrasonic echo ranger: tick predictor, stimulus and checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import uer_pkg::*;

    // Two register stages between a sample transfer and its result transfer.
    localparam int PIPE_LATENCY   = 2;
    localparam int HOLD_CYCLES    = 60;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_SAMPLES  = 70;
    localparam int PRINT_LIMIT    = 40;

    typedef enum logic [1:0] {RNG_IDLE, RNG_WAIT, RNG_COUNT, RNG_GAP} t_rng_phase;
    typedef enum logic [1:0] {PACE_FULL, PACE_COIN, PACE_SPARSE, PACE_ALTERNATE} t_rx_pace;

    // Tick-level predictor of the ranger plus the queue of results it still owes.
    class RangeScoreboard;
        logic                       retry_on;
        logic [7:0]                 attempt_limit;
        logic [15:0]                fail_value;
        logic [15:0]                window_lo;
        logic [15:0]                window_hi;
        logic [15:0]                speed;
        t_rng_phase                 phase;
        logic [COUNT_WIDTH_DEF-1:0] pulses;
        logic [7:0]                 attempts;
        logic [GAP_W-1:0]           gap_ticks;
        t_res                       pending[$];
        int                         errors;

        function new();
            errors        = 0;
            retry_on      = RST_RETRY_ENABLE;
            attempt_limit = RST_MAX_ATTEMPTS;
            fail_value    = RST_BAD_VALUE;
            window_lo     = RST_MIN_DISTANCE;
            window_hi     = RST_MAX_DISTANCE;
            speed         = RST_SPEED_SCALE;
            phase         = RNG_IDLE;
            pulses        = '0;
            attempts      = '0;
            gap_ticks     = '0;
        endfunction

        // only the low bits of each register survive
        function void write_reg(t_reg_idx idx, logic [31:0] data);
            case (idx)
                REG_RETRY_ENABLE: retry_on      = data[0];
                REG_MAX_ATTEMPTS: attempt_limit = data[7:0];
                REG_BAD_VALUE:    fail_value    = data[15:0];
                REG_MIN_DISTANCE: window_lo     = data[15:0];
                REG_MAX_DISTANCE: window_hi     = data[15:0];
                REG_SPEED_SCALE:  speed         = data[15:0];
                default: ;
            endcase
        endfunction

        function bit next_attempt();
            if (attempts >= attempt_limit) return 1'b0;
            attempts  = attempts + 8'd1;
            pulses    = '0;
            gap_ticks = '0;
            phase     = RNG_WAIT;
            return 1'b1;
        endfunction

        // (count * speed) >> 17, clamped
        function logic [15:0] echo_distance();
            logic [COUNT_WIDTH_DEF+15:0] product;
            product = (pulses * speed) >> SPEED_SHIFT;
            if (product > DIST_MAX) return 16'(DIST_MAX);
            return product[15:0];
        endfunction

        function void note_sample(logic start, logic echo);
            t_res        r;
            logic [15:0] echo_dist;
            bit          give_up;
            r       = '0;
            give_up = 1'b0;
            case (phase)
                RNG_IDLE: begin
                    if (start) begin
                        attempts = '0;
                        give_up  = !next_attempt();
                    end
                end
                RNG_WAIT: begin
                    if (echo) begin
                        pulses = 1;
                        phase  = RNG_COUNT;
                    end
                end
                RNG_COUNT: begin
                    if (echo) begin
                        if (pulses != {COUNT_WIDTH_DEF{1'b1}}) pulses = pulses + 1'b1;
                    end else begin
                        echo_dist = echo_distance();
                        if ($signed(echo_dist) >= $signed(window_lo) &&
                            $signed(echo_dist) <= $signed(window_hi)) begin
                            r.done_res    = 1'b1;
                            r.range_value = echo_dist;
                            phase         = RNG_IDLE;
                        end else if (retry_on) begin
                            gap_ticks = 1;
                            phase     = RNG_GAP;
                            if (gap_ticks >= RETRY_GAP_TICKS) give_up = !next_attempt();
                        end else begin
                            give_up = 1'b1;
                        end
                    end
                end
                default: begin
                    gap_ticks = gap_ticks + 1'b1;
                    if (gap_ticks >= RETRY_GAP_TICKS) give_up = !next_attempt();
                end
            endcase
            if (give_up) begin
                phase         = RNG_IDLE;
                r.done_res    = 1'b1;
                r.range_value = fail_value;
                r.bad_reading = 1'b1;
            end
            r.trigger_level = !(phase == RNG_WAIT || phase == RNG_COUNT);
            r.busy_res      = (phase != RNG_IDLE);
            pending.push_back(r);
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            if (errors < PRINT_LIMIT)
                $display("%0t ns: bad %s, got %h, want %h", $time, what, got, want);
            errors++;
        endtask

        task check_result(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing owed", got.range_value, 16'h0);
                return;
            end
            want = pending.pop_front();
            if (got.trigger_level !== want.trigger_level)
                report_mismatch("trigger_level", got.trigger_level, want.trigger_level);
            if (got.done_res !== want.done_res)
                report_mismatch("done_res", got.done_res, want.done_res);
            if (got.range_value !== want.range_value)
                report_mismatch("range_value", got.range_value, want.range_value);
            if (got.bad_reading !== want.bad_reading)
                report_mismatch("bad_reading", got.bad_reading, want.bad_reading);
            if (got.busy_res !== want.busy_res)
                report_mismatch("busy_res", got.busy_res, want.busy_res);
        endtask
    endclass

    // Block ports; every input is known from time zero.
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  i_start_req  = 1'b0;
    logic                  i_echo_level = 1'b0;
    logic                  i_ready      = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic                  o_ready;
    logic                  o_valid;
    logic                  o_trigger_level;
    logic                  o_done_res;
    logic signed [15:0]    o_range_value;
    logic                  o_bad_reading;
    logic                  o_busy_res;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    RangeScoreboard sb = new();

    // Sender pacing: bursts of back-to-back transfers split by random gaps.
    int burst_left = 0;
    int gap_max    = 4;
    int accepted   = 0;

    // Receiver pacing; hold_req asks the receiver for one long hold-off.
    bit       hold_req  = 1'b0;
    int       hold_left = 0;
    int       rx_tick   = 0;
    t_rx_pace rx_pace   = PACE_FULL;
    t_res     seen;

    ultrasonic_echo_ranger dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_start_req     (i_start_req),
        .i_echo_level    (i_echo_level),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_trigger_level (o_trigger_level),
        .o_done_res      (o_done_res),
        .o_range_value   (o_range_value),
        .o_bad_reading   (o_bad_reading),
        .o_busy_res      (o_busy_res),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Offer one tick sample and hold it until the transfer happens. The predictor
    // steps at the accepting edge, so callers can steer the next sample from its
    // phase. valid stays high between back-to-back samples.
    task automatic send_tick(logic start, logic echo);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
            // now and then switch to long gapless stretches, or back
            if ($urandom_range(0, 7) == 0) gap_max = $urandom_range(0, 1) ? 0 : 6;
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_start_req  <= start;
        i_echo_level <= echo;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(start, echo);
        accepted++;
    endtask

    // APB write, setup then access phase; high bits past the register width are junk on purpose.
    task automatic reg_write(t_reg_idx idx, logic [31:0] value);
        logic [31:0] keep;
        keep = (idx == REG_RETRY_ENABLE) ? 32'h1 :
               (idx == REG_MAX_ATTEMPTS) ? 32'hFF : 32'hFFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (value & keep) | ($urandom & ~keep);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.write_reg(idx, pwdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One ranging request shaped like a real sensor: the echo rises after
    // wait_len low ticks and stays high for high_len ticks, on every attempt.
    // Start toggles at random while busy (ignored) and the echo is noise in
    // the retry gap. Returns with the block idle.
    task automatic range_once(int wait_len, int high_len);
        int   waited;
        int   highs;
        logic echo;
        waited = 0;
        highs  = 0;
        send_tick(1'b1, $urandom_range(0, 1));
        while (sb.phase != RNG_IDLE) begin
            case (sb.phase)
                RNG_WAIT: begin
                    echo = (waited >= wait_len);
                    waited++;
                    if (echo) highs = 1;
                end
                RNG_COUNT: begin
                    echo = (highs < high_len);
                    if (echo) highs++;
                end
                default: begin
                    echo   = $urandom_range(0, 1);
                    waited = 0;
                    highs  = 0;
                end
            endcase
            send_tick($urandom_range(0, 1), echo);
        end
    endtask

    // Finish whatever ranging is running, let every result arrive, then wait
    // out the pipeline so a register write lands on an idle block.
    task automatic quiesce();
        while (sb.phase != RNG_IDLE) send_tick(1'b0, sb.phase == RNG_WAIT);
        i_valid    <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    // Receiver: check each result transfer, then pick ready for the next edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen.trigger_level = o_trigger_level;
            seen.done_res      = o_done_res;
            seen.range_value   = o_range_value;
            seen.bad_reading   = o_bad_reading;
            seen.busy_res      = o_busy_res;
            sb.check_result(seen);
        end
        rx_tick++;
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_req) begin
            // long hold-off: both pipeline stages fill and o_ready must drop
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_ready   <= 1'b0;
        end else begin
            if (rx_tick % 50 == 0) rx_pace = t_rx_pace'($urandom_range(0, 3));
            case (rx_pace)
                PACE_FULL:   i_ready <= 1'b1;
                PACE_COIN:   i_ready <= $urandom_range(0, 1);
                PACE_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                default:     i_ready <= rx_tick[0];
            endcase
        end
    end

    initial begin : stimulus
        int lo;
        int hi;
        int phase_base;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: reset settings first ---
        range_once(2, 3);               // short pulse, distance 0 inside window
        range_once(0, 1);               // echo already high on first waiting tick
        quiesce();
        reg_write(REG_MAX_ATTEMPTS, 0); // zero attempt limit: bad value on the start tick
        range_once(0, 1);

        // out of window twice: two retry gaps, then the bad value at the gap end
        quiesce();
        reg_write(REG_MAX_ATTEMPTS, 2);
        reg_write(REG_BAD_VALUE, 32'h8000);
        reg_write(REG_SPEED_SCALE, 32'hFFFF);
        reg_write(REG_MIN_DISTANCE, 10);
        range_once(1, 4);
        range_once(0, 30);              // distance 14, accepted on the first try
        quiesce();
        reg_write(REG_RETRY_ENABLE, 0); // no retry: bad value as the echo falls
        range_once(0, 4);

        // widest window, full speed, long pulse
        quiesce();
        reg_write(REG_RETRY_ENABLE, 1);
        reg_write(REG_MIN_DISTANCE, 32'hFFFF8000);
        reg_write(REG_MAX_DISTANCE, 32767);
        reg_write(REG_BAD_VALUE, 32767);
        reg_write(REG_MAX_ATTEMPTS, 6);
        range_once(3, 150);

        // empty window (min above max), zero speed: all six attempts fail
        quiesce();
        reg_write(REG_SPEED_SCALE, 0);
        reg_write(REG_MIN_DISTANCE, 1);
        reg_write(REG_MAX_DISTANCE, 0);
        range_once(0, 1);

        // --- random phases, each with its own register settings ---
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            quiesce();
            reg_write(REG_RETRY_ENABLE, $urandom_range(0, 3) != 0);
            reg_write(REG_MAX_ATTEMPTS, $urandom_range(0, 5));
            reg_write(REG_BAD_VALUE, $urandom);
            case ($urandom_range(0, 4))
                0:       reg_write(REG_SPEED_SCALE, 32'hFFFF);
                1:       reg_write(REG_SPEED_SCALE, 0);
                2:       reg_write(REG_SPEED_SCALE, RST_SPEED_SCALE);
                3:       reg_write(REG_SPEED_SCALE, $urandom);
                default: reg_write(REG_SPEED_SCALE, $urandom_range(20000, 65535));
            endcase
            case ($urandom_range(0, 4))
                0: begin
                    lo = $urandom_range(0, 12);
                    hi = lo + $urandom_range(0, 12);
                end
                1: begin
                    lo = -32768;
                    hi = 32767;
                end
                2: begin
                    lo = $urandom;
                    hi = $urandom;
                end
                3: begin
                    lo = $urandom_range(0, 8);
                    hi = lo;
                end
                default: begin              // window wholly below zero
                    lo = -int'($urandom_range(1, 100));
                    hi = -1;
                end
            endcase
            reg_write(REG_MIN_DISTANCE, lo);
            reg_write(REG_MAX_DISTANCE, hi);

            if (ph == 2 || ph == 5) hold_req = 1'b1;
            phase_base = accepted;
            while (accepted - phase_base < PHASE_SAMPLES) begin
                if ($urandom_range(0, 9) < 8) begin
                    range_once($urandom_range(0, 6),
                               ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                           : $urandom_range(1, 40));
                end else begin
                    // noise: stray starts and echo glitches, sequences left half done
                    repeat ($urandom_range(1, 12))
                        send_tick($urandom_range(0, 7) == 0, $urandom_range(0, 1));
                end
            end
        end

        quiesce();
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #40ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

### ultrasonic_echo_ranger.f
+incdir+rtl
rtl/uer_pkg.sv
rtl/uer_regs.sv
rtl/uer_dist.sv
rtl/uer_ctrl.sv
rtl/ultrasonic_echo_ranger.sv
bench/testbench.sv
